### rtl/wspd_pkg.sv
// Shared types and constants of the wheel speed PID drive block.
`timescale 1ns / 1ps
`default_nettype none

package wspd_pkg;

  localparam int unsigned ErrW  = 18;
  localparam int unsigned IntW  = 40;
  localparam int unsigned AccW  = 42;
  localparam int unsigned MulAW = 17;
  localparam int unsigned MulBW = 19;
  localparam int unsigned ProdW = MulAW + MulBW;

  localparam int unsigned AddrW = 5;

  localparam logic [2:0] RegPropGain   = 3'd0;
  localparam logic [2:0] RegIntegGain  = 3'd1;
  localparam logic [2:0] RegDerivGain  = 3'd2;
  localparam logic [2:0] RegWheelRad   = 3'd3;
  localparam logic [2:0] RegMinDrive   = 3'd4;
  localparam logic [2:0] RegMaxDrive   = 3'd5;

  localparam logic [15:0] PropGainRst  = 16'd42752;
  localparam logic [15:0] IntegGainRst = 16'd26;
  localparam logic [15:0] DerivGainRst = 16'd102;
  localparam logic [15:0] WheelRadRst  = 16'd4719;
  localparam logic [7:0]  MinDriveRst  = 8'd45;
  localparam logic [7:0]  MaxDriveRst  = 8'd255;

  typedef enum logic [1:0] {
    MUL_RATE  = 2'd0,
    MUL_INTEG = 2'd1,
    MUL_PROP  = 2'd2,
    MUL_DERIV = 2'd3
  } mul_sel_e;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [15:0] wheel_radius;
    logic [7:0]  min_drive;
    logic [7:0]  max_drive;
  } wspd_cfg_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     err_en;
    logic     integ_en;
    logic     acc_init;
    logic     acc_add;
    logic     finish;
  } wspd_cmd_t;

endpackage

`default_nettype wire

### rtl/wspd_regs.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
`default_nettype none

module wspd_regs
  import wspd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output wspd_cfg_t             cfg_o
);

  wspd_cfg_t   cfg_q, cfg_d;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegPropGain:  cfg_d.prop_gain    = pwdata[15:0];
        RegIntegGain: cfg_d.integ_gain   = pwdata[15:0];
        RegDerivGain: cfg_d.deriv_gain   = pwdata[15:0];
        RegWheelRad:  cfg_d.wheel_radius = pwdata[15:0];
        RegMinDrive:  cfg_d.min_drive    = pwdata[7:0];
        RegMaxDrive:  cfg_d.max_drive    = pwdata[7:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPropGain:  prdata = {16'd0, cfg_q.prop_gain};
      RegIntegGain: prdata = {16'd0, cfg_q.integ_gain};
      RegDerivGain: prdata = {16'd0, cfg_q.deriv_gain};
      RegWheelRad:  prdata = {16'd0, cfg_q.wheel_radius};
      RegMinDrive:  prdata = {24'd0, cfg_q.min_drive};
      RegMaxDrive:  prdata = {24'd0, cfg_q.max_drive};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain    <= PropGainRst;
      cfg_q.integ_gain   <= IntegGainRst;
      cfg_q.deriv_gain   <= DerivGainRst;
      cfg_q.wheel_radius <= WheelRadRst;
      cfg_q.min_drive    <= MinDriveRst;
      cfg_q.max_drive    <= MaxDriveRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### rtl/wspd_dp.sv
// Datapath of the PID drive: shared multiplier, error, integrator and output stage.
`timescale 1ns / 1ps
`default_nettype none

module wspd_dp
  import wspd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wspd_cfg_t               cfg_i,
  input  wspd_cmd_t               cmd_i,
  input  wire logic signed [15:0] target_speed_i,
  input  wire logic signed [15:0] measured_rate_i,
  output logic signed [8:0]       drive_o
);

  logic signed [15:0]      target_q, rate_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [ErrW-1:0]  err_q, err_d;
  logic signed [ErrW-1:0]  last_q;
  logic signed [IntW-1:0]  integ_q, integ_new_q, integ_new_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [8:0]       drive_q, drive_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulBW-1:0] err_diff;

  logic        [ProdW-1:0] p_mag, p_rnd;
  logic signed [ProdW-1:0] e_rnd, e_sub;

  logic signed [IntW:0]    i_sum;

  logic        [AccW-1:0]  a_mag, a_rnd;
  logic        [21:0]      mv_mag, lift_mag, sat_mag;
  logic                    mv_neg;

  assign err_diff = MulBW'(err_q) - MulBW'(last_q);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RATE: begin
        mul_a = {1'b0, cfg_i.wheel_radius};
        mul_b = MulBW'(rate_q);
      end
      MUL_INTEG: begin
        mul_a = {1'b0, cfg_i.integ_gain};
        mul_b = MulBW'(err_q);
      end
      MUL_PROP: begin
        mul_a = {1'b0, cfg_i.prop_gain};
        mul_b = MulBW'(err_q);
      end
      MUL_DERIV: begin
        mul_a = {1'b0, cfg_i.deriv_gain};
        mul_b = err_diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  // Speed error: product rounded half away from zero by 12 bits, less target, saturated.
  always_comb begin
    p_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
    p_rnd = (p_mag + ProdW'(2048)) >> 12;
    e_rnd = prod_q[ProdW-1] ? -$signed(p_rnd) : $signed(p_rnd);
    e_sub = e_rnd - ProdW'(target_q);
    if (e_sub > ProdW'(131071)) begin
      err_d = {1'b0, {(ErrW-1){1'b1}}};
    end else if (e_sub < -ProdW'(131072)) begin
      err_d = {1'b1, {(ErrW-1){1'b0}}};
    end else begin
      err_d = e_sub[ErrW-1:0];
    end
  end

  always_comb begin
    i_sum = (IntW+1)'(integ_q) + (IntW+1)'(prod_q);
    if (i_sum[IntW] != i_sum[IntW-1]) begin
      integ_new_d = i_sum[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end else begin
      integ_new_d = i_sum[IntW-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_init) begin
      acc_d = AccW'(integ_new_q) + AccW'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  // Output stage: round by 20 bits, sign check, minimum lift and saturation.
  always_comb begin
    a_mag  = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
    a_rnd  = (a_mag + AccW'(20'h80000)) >> 20;
    mv_neg = acc_q[AccW-1];
    mv_mag = a_rnd[21:0];
    if (mv_mag != 22'd0 && mv_neg == target_q[15]) begin
      mv_mag = 22'd0;
    end
    lift_mag = mv_mag;
    if (mv_mag != 22'd0 && mv_mag <= {14'd0, cfg_i.min_drive}) begin
      lift_mag = {14'd0, cfg_i.min_drive};
    end
    sat_mag = lift_mag;
    if (lift_mag > {14'd0, cfg_i.max_drive}) begin
      sat_mag = {14'd0, cfg_i.max_drive};
    end
    if (target_q == 16'sd0) begin
      drive_d = 9'sd0;
    end else if (mv_neg) begin
      drive_d = 9'd0 - {1'b0, sat_mag[7:0]};
    end else begin
      drive_d = {1'b0, sat_mag[7:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= target_speed_i;
      rate_q   <= measured_rate_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.err_en) begin
      err_q <= err_d;
    end
    if (cmd_i.integ_en) begin
      integ_new_q <= integ_new_d;
    end
    acc_q <= acc_d;
    if (cmd_i.finish) begin
      drive_q <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else if (cmd_i.finish) begin
      if (target_q == 16'sd0) begin
        integ_q <= '0;
        last_q  <= '0;
      end else begin
        integ_q <= integ_new_q;
        last_q  <= err_q;
      end
    end
  end

  assign drive_o = drive_q;

endmodule

`default_nettype wire

### rtl/wspd_ctrl.sv
// Controller state machine that sequences the datapath and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module wspd_ctrl
  import wspd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output wspd_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MERR = 8'b0000_0010,
    S_ERR  = 8'b0000_0100,
    S_MI   = 8'b0000_1000,
    S_INT  = 8'b0001_0000,
    S_P    = 8'b0010_0000,
    S_D    = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_RATE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MERR;
        end
      end
      S_MERR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RATE;
        state_d       = S_ERR;
      end
      S_ERR: begin
        cmd_o.err_en = 1'b1;
        state_d      = S_MI;
      end
      S_MI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_INTEG;
        state_d       = S_INT;
      end
      S_INT: begin
        cmd_o.integ_en = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_PROP;
        state_d        = S_P;
      end
      S_P: begin
        cmd_o.acc_init = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_DERIV;
        state_d        = S_D;
      end
      S_D: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !(out_valid_q && out_stall_i))
    else $error("Result register written while a transaction was still pending.");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_MERR))
    else $error("Accepted transaction did not start the multiply sequence.");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("Finished transaction did not present a result.");

  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> in_accept)
    else $error("Operands loaded without an accepted transaction.");
`endif

endmodule

`default_nettype wire

### rtl/wheel_speed_pid_drive.sv
// Top level of the wheel speed PID drive block.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted transaction carries a target linear speed (Q3.12) and a measured
// wheel rate (Q7.8) and yields one signed drive value. No new transaction is
// accepted until the last one is back in idle; the result is registered as the
// final state is left. The sequence is set by the single 17 by 19 bit multiplier,
// used four times per transaction. A stalled output holds back the next result
// until the last is taken. Users must write gains, wheel radius and drive limits
// through the APB-style port while idle; the block itself does not enforce it.

module wheel_speed_pid_drive
  import wspd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] target_speed_i,
  input  wire logic signed [15:0] measured_rate_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [8:0]       drive_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  wspd_cfg_t cfg;
  wspd_cmd_t cmd;

  wspd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wspd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  wspd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .target_speed_i  (target_speed_i),
    .measured_rate_i (measured_rate_i),
    .drive_o         (drive_o)
  );

endmodule

`default_nettype wire

### bench/wheel_speed_pid_drive_tb.sv
// Self-checking testbench for the wheel speed PID drive block.
`timescale 1ns / 1ps

module wheel_speed_pid_drive_tb;
  import wspd_pkg::*;

  localparam int          QuietLimit  = 2000;
  localparam int          HoldCycles  = 200;
  localparam int          MaxReported = 50;
  localparam logic [2:0]  RegSpareA   = 3'd6;
  localparam logic [2:0]  RegSpareB   = 3'd7;
  localparam longint      ErrMax      = (longint'(1) <<< (ErrW - 1)) - 1;
  localparam longint      ErrMin      = -ErrMax - 1;
  localparam longint      IntMax      = (longint'(1) <<< (IntW - 1)) - 1;
  localparam longint      IntMin      = -IntMax - 1;
  localparam wspd_cfg_t   DefaultCfg  = '{PropGainRst, IntegGainRst, DerivGainRst,
                                          WheelRadRst, MinDriveRst, MaxDriveRst};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [15:0]    target_speed_i;
  logic signed [15:0]    measured_rate_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [8:0]     drive_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AddrW-1:0]      paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  wspd_cfg_t             cfg_model;
  logic signed [IntW-1:0] integ_acc;
  logic signed [ErrW-1:0] prev_err;
  logic signed [8:0]     drive_q[$];

  int unsigned           tx_gap_max;
  int unsigned           rx_gap_max;
  bit                    hold_request;
  int                    mismatches;
  int                    items_accepted;
  int                    results_checked;
  int                    settings_applied;

  wheel_speed_pid_drive dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .target_speed_i (target_speed_i),
    .measured_rate_i(measured_rate_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint round_away(input longint x, input int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (x >= 0) begin
      return (x + half) >>> s;
    end
    return -((-x + half) >>> s);
  endfunction

  function automatic longint clamp(input longint x, input longint lo, input longint hi);
    if (x < lo) begin
      return lo;
    end
    return (x > hi) ? hi : x;
  endfunction

  // Works out the drive for one transaction and advances the controller state.
  function automatic logic signed [8:0] predict_drive(input logic signed [15:0] tgt,
                                                      input logic signed [15:0] rate);
    longint t;
    longint err;
    longint integ;
    longint sum;
    longint mv;
    longint lo;
    longint hi;
    t  = tgt;
    lo = longint'(cfg_model.min_drive);
    hi = longint'(cfg_model.max_drive);
    if (t == 0) begin
      integ_acc = '0;
      prev_err  = '0;
      return '0;
    end
    err = round_away(longint'(rate) * longint'(cfg_model.wheel_radius), 12) - t;
    err = clamp(err, ErrMin, ErrMax);
    integ = clamp(longint'(integ_acc) + longint'(cfg_model.integ_gain) * err, IntMin, IntMax);
    sum = longint'(cfg_model.prop_gain) * err + integ
        + longint'(cfg_model.deriv_gain) * (err - longint'(prev_err));
    mv = round_away(sum, 20);
    if ((mv < 0 && t < 0) || (mv > 0 && t > 0)) begin
      mv = 0;
    end
    integ_acc = integ[IntW-1:0];
    prev_err  = err[ErrW-1:0];
    if (mv < 0 && mv >= -lo) begin
      mv = -lo;
    end
    if (mv > 0 && mv <= lo) begin
      mv = lo;
    end
    if (mv > hi) begin
      mv = hi;
    end
    if (mv < -hi) begin
      mv = -hi;
    end
    return mv[8:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxReported) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    logic signed [8:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        drive_q.push_back(predict_drive(target_speed_i, measured_rate_i));
        items_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("drive %0d arrived with no transaction pending", drive_o));
        end else begin
          want = drive_q.pop_front();
          results_checked++;
          if (drive_o !== want) begin
            report_mismatch($sformatf("drive is %0d, expected %0d", drive_o, want));
          end
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      int n;
      if (hold_request) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end
      n = $urandom_range(0, rx_gap_max);
      if (n > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no transaction for %0d cycles.", QuietLimit);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegPropGain:  cfg_model.prop_gain    = data[15:0];
      RegIntegGain: cfg_model.integ_gain   = data[15:0];
      RegDerivGain: cfg_model.deriv_gain   = data[15:0];
      RegWheelRad:  cfg_model.wheel_radius = data[15:0];
      RegMinDrive:  cfg_model.min_drive    = data[7:0];
      RegMaxDrive:  cfg_model.max_drive    = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] idx, output logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_registers(input string when);
    logic [31:0] got;
    logic [31:0] want;
    for (int i = RegPropGain; i <= RegMaxDrive; i++) begin
      apb_read(3'(i), got);
      case (3'(i))
        RegPropGain:  want = {16'h0, cfg_model.prop_gain};
        RegIntegGain: want = {16'h0, cfg_model.integ_gain};
        RegDerivGain: want = {16'h0, cfg_model.deriv_gain};
        RegWheelRad:  want = {16'h0, cfg_model.wheel_radius};
        RegMinDrive:  want = {24'h0, cfg_model.min_drive};
        default:      want = {24'h0, cfg_model.max_drive};
      endcase
      if (got !== want) begin
        report_mismatch($sformatf("register %0d reads %h %s, expected %h", i, got, when, want));
      end
    end
  endtask

  task automatic set_config(input wspd_cfg_t c);
    apb_write(RegPropGain,  {16'h0, c.prop_gain});
    apb_write(RegIntegGain, {16'h0, c.integ_gain});
    apb_write(RegDerivGain, {16'h0, c.deriv_gain});
    apb_write(RegWheelRad,  {16'h0, c.wheel_radius});
    apb_write(RegMinDrive,  {24'h0, c.min_drive});
    apb_write(RegMaxDrive,  {24'h0, c.max_drive});
    settings_applied++;
  endtask

  task automatic send_item(input logic signed [15:0] tgt, input logic signed [15:0] rate);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    target_speed_i  <= tgt;
    measured_rate_i <= rate;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // A drift sign other than zero keeps the speed error mostly on one side,
  // which winds the integrator up towards its limits.
  task automatic random_item(input int drift_sign);
    int kind;
    int m;
    logic signed [15:0] t;
    logic signed [15:0] r;
    kind = $urandom_range(0, 9);
    if (drift_sign != 0 && kind < 6) begin
      r = 16'(drift_sign * int'($urandom_range(500, 32767)));
      t = 16'(-drift_sign * int'($urandom_range(1, 32767)));
    end else if (kind == 0) begin
      t = '0;
      r = 16'($urandom());
    end else if (kind < 4) begin
      t = 16'($urandom());
      r = 16'($urandom());
    end else begin
      m = $urandom_range(1, 4000);
      t = 16'($urandom_range(0, 1) ? m : -m);
      r = 16'(int'($urandom_range(0, 6000)) - 3000);
    end
    send_item(t, r);
  endtask

  function automatic logic [15:0] pick_value(input int width, input logic [15:0] rst_val);
    logic [15:0] mask;
    mask = 16'hFFFF >> (16 - width);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return mask;
      2:       return rst_val;
      default: return 16'($urandom()) & mask;
    endcase
  endfunction

  task automatic test_register_access();
    check_registers("after reset");
    for (int i = RegPropGain; i <= RegMaxDrive; i++) begin
      apb_write(3'(i), $urandom());
    end
    check_registers("after wide writes");
    apb_write(RegSpareA, 32'hFFFF_FFFF);
    apb_write(RegSpareB, $urandom());
    check_registers("after writes to unused addresses");
    set_config(DefaultCfg);
  endtask

  task automatic test_special_cases();
    wspd_cfg_t c;
    tx_gap_max = 3;
    rx_gap_max = 3;
    send_item(16'sd0, 16'sd100);
    send_item(16'sh7FFF, 16'sh7FFF);
    send_item(16'sh8000, 16'sh8000);
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'sh8000, 16'sh7FFF);
    send_item(16'sd1, 16'sd0);
    send_item(-16'sd1, 16'sd0);
    send_item(16'sd500, 16'sd0);
    send_item(-16'sd500, 16'sd0);
    send_item(-16'sd500, -16'sd2000);
    send_item(16'sd500, 16'sd2000);
    send_item(16'sd0, 16'sd0);
    drain_results();
    c = DefaultCfg;
    c.min_drive = 8'd200;
    c.max_drive = 8'd100;
    set_config(c);
    send_item(16'sd500, 16'sd0);
    send_item(-16'sd20000, 16'sd0);
    send_item(16'sd20000, 16'sd0);
    drain_results();
    c.min_drive = MinDriveRst;
    c.max_drive = 8'd0;
    set_config(c);
    send_item(16'sd500, 16'sd0);
    send_item(-16'sd500, 16'sd0);
    drain_results();
    c.min_drive = 8'd0;
    c.max_drive = MaxDriveRst;
    set_config(c);
    send_item(16'sd1, 16'sd0);
    send_item(-16'sd300, 16'sd0);
    send_item(16'sd4000, 16'sd0);
    drain_results();
    set_config(DefaultCfg);
  endtask

  task automatic test_random_phases();
    wspd_cfg_t c;
    int drift;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: c = DefaultCfg;
        1: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF};
        2: c = '{16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0};
        3: c = '{PropGainRst, 16'hFFFF, DerivGainRst, WheelRadRst, 8'd200, 8'd100};
        default: begin
          c.prop_gain    = pick_value(16, PropGainRst);
          c.integ_gain   = pick_value(16, IntegGainRst);
          c.deriv_gain   = pick_value(16, DerivGainRst);
          c.wheel_radius = pick_value(16, WheelRadRst);
          c.min_drive    = 8'(pick_value(8, 16'(MinDriveRst)));
          c.max_drive    = 8'(pick_value(8, 16'(MaxDriveRst)));
        end
      endcase
      set_config(c);
      check_registers("after a new setting");
      tx_gap_max = (p % 4 < 2) ? ((p % 2 == 0) ? 15 : 0) : ((p % 4 == 2) ? 15 : 0);
      rx_gap_max = (p % 4 < 2) ? tx_gap_max : 15 - tx_gap_max;
      drift = (p == 1 || p % 3 == 2) ? ($urandom_range(0, 1) ? 1 : -1) : 0;
      for (int i = 0; i < 100; i++) begin
        random_item(drift);
      end
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    set_config(DefaultCfg);
    tx_gap_max   = 0;
    rx_gap_max   = 3;
    hold_request = 1'b1;
    for (int i = 0; i < 50; i++) begin
      random_item(0);
    end
    drain_results();
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    target_speed_i   = '0;
    measured_rate_i  = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    cfg_model        = DefaultCfg;
    integ_acc        = '0;
    prev_err         = '0;
    tx_gap_max       = 15;
    rx_gap_max       = 15;
    hold_request     = 1'b0;
    mismatches       = 0;
    items_accepted   = 0;
    results_checked  = 0;
    settings_applied = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_register_access();
    test_special_cases();
    test_random_phases();
    test_backpressure();
    drain_results();

    $display("Summary: %0d transactions accepted, %0d drive results checked, %0d settings applied.",
             items_accepted, results_checked, settings_applied);
    $display("Covered zero targets, sign clamping, minimum lift, saturation, windup and back-pressure.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
